>>> hdl/ptlb_pkg.sv
// Shared types and constants for the paging TLB translate unit.
`default_nettype none
package ptlb_pkg;

    localparam int ADDR_W      = 32;
    localparam int PAGE_OFS_W  = 12;
    localparam int PAGE_W      = ADDR_W - PAGE_OFS_W;
    localparam int DIR_IDX_W   = 10;
    localparam int TLB_ENTRIES = 32;
    localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGING_EN = 1'b0,
        CFG_DIR_BASE  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_XLATE   = 2'd0,
        CMD_MEMDATA = 2'd1,
        CMD_FLUSH   = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_XLATE     = 2'd0,
        KIND_RDREQ     = 2'd1,
        KIND_DIR_FAULT = 2'd2,
        KIND_TBL_FAULT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DIR  = 2'd1,
        PH_TBL  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        SEL_ZERO = 3'd0,
        SEL_LIN  = 3'd1,
        SEL_HIT  = 3'd2,
        SEL_DIR  = 3'd3,
        SEL_TBL  = 3'd4,
        SEL_FILL = 3'd5
    } addr_sel_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] lin_addr;
        logic [ADDR_W-1:0] mem_data;
    } in_req_t;

    typedef struct packed {
        kind_t             out_kind;
        logic [ADDR_W-1:0] out_addr;
    } out_res_t;

    typedef struct packed {
        logic      load_out;
        kind_t     kind;
        addr_sel_t sel;
        logic      pend_load;
        logic      fill;
        logic      flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic paging_en;
        logic hit;
        logic present;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/ptlb_ctrl.sv
// Walk controller: handshake, walk phase and datapath commands.
`default_nettype none
module ptlb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  ptlb_pkg::cmd_t        req_cmd,
    input  ptlb_pkg::dp_status_t  status,
    output ptlb_pkg::ctrl_cmd_t   cmd
);
    import ptlb_pkg::*;

    phase_t phase_reg, phase_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (req_cmd)
                CMD_XLATE: begin
                    if (phase_reg == PH_IDLE && status.paging_en && !status.hit) begin
                        phase_next = PH_DIR;
                    end
                end
                CMD_MEMDATA: begin
                    case (phase_reg)
                        PH_DIR:  phase_next = status.present ? PH_TBL : PH_IDLE;
                        PH_TBL:  phase_next = PH_IDLE;
                        default: phase_next = phase_reg;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_comb begin
        cmd = '{load_out: 1'b0, kind: KIND_XLATE, sel: SEL_ZERO,
                pend_load: 1'b0, fill: 1'b0, flush: 1'b0};
        if (accept) begin
            case (req_cmd)
                CMD_XLATE: begin
                    if (phase_reg == PH_IDLE) begin
                        cmd.load_out = 1'b1;
                        if (!status.paging_en) begin
                            cmd.sel = SEL_LIN;
                        end else if (status.hit) begin
                            cmd.sel = SEL_HIT;
                        end else begin
                            cmd.kind      = KIND_RDREQ;
                            cmd.sel       = SEL_DIR;
                            cmd.pend_load = 1'b1;
                        end
                    end
                end
                CMD_MEMDATA: begin
                    case (phase_reg)
                        PH_DIR: begin
                            cmd.load_out = 1'b1;
                            if (status.present) begin
                                cmd.kind = KIND_RDREQ;
                                cmd.sel  = SEL_TBL;
                            end else begin
                                cmd.kind = KIND_DIR_FAULT;
                            end
                        end
                        PH_TBL: begin
                            cmd.load_out = 1'b1;
                            if (status.present) begin
                                cmd.sel  = SEL_FILL;
                                cmd.fill = 1'b1;
                            end else begin
                                cmd.kind = KIND_TBL_FAULT;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_FLUSH: cmd.flush = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/ptlb_dp.sv
// Datapath: config registers, TLB store, pending address and result register.
`default_nettype none
module ptlb_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ptlb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptlb_pkg::ADDR_W-1:0]      cfg_wdata,
    input  ptlb_pkg::in_req_t                req,
    input  ptlb_pkg::ctrl_cmd_t              cmd,
    output ptlb_pkg::dp_status_t             status,
    output ptlb_pkg::out_res_t               res
);
    import ptlb_pkg::*;

    logic                   paging_en_reg;
    logic [ADDR_W-1:0]      dir_base_reg;
    logic [ADDR_W-1:0]      pending_addr_reg;
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [PAGE_W-1:0]      tlb_tag_reg   [TLB_ENTRIES];
    logic [PAGE_W-1:0]      tlb_frame_reg [TLB_ENTRIES];
    out_res_t               res_reg;

    logic [TLB_IDX_W-1:0]   look_slot;
    logic [TLB_IDX_W-1:0]   fill_slot;
    logic [ADDR_W-1:0]      addr_next;

    // slot = page number modulo entry count
    assign look_slot = req.lin_addr[PAGE_OFS_W +: TLB_IDX_W];
    assign fill_slot = pending_addr_reg[PAGE_OFS_W +: TLB_IDX_W];

    assign status.paging_en = paging_en_reg;
    assign status.hit       = tlb_valid_reg[look_slot] &&
                              (tlb_tag_reg[look_slot] == req.lin_addr[ADDR_W-1:PAGE_OFS_W]);
    assign status.present   = req.mem_data[0];

    always_comb begin
        case (cmd.sel)
            SEL_LIN:  addr_next = req.lin_addr;
            SEL_HIT:  addr_next = {tlb_frame_reg[look_slot],
                                   req.lin_addr[PAGE_OFS_W-1:0]};
            SEL_DIR:  addr_next = dir_base_reg +
                                  {{(ADDR_W-DIR_IDX_W-2){1'b0}},
                                   req.lin_addr[ADDR_W-1 -: DIR_IDX_W], 2'b00};
            SEL_TBL:  addr_next = {req.mem_data[ADDR_W-1:PAGE_OFS_W], {PAGE_OFS_W{1'b0}}} +
                                  {{(ADDR_W-DIR_IDX_W-2){1'b0}},
                                   pending_addr_reg[PAGE_OFS_W +: DIR_IDX_W], 2'b00};
            SEL_FILL: addr_next = {req.mem_data[ADDR_W-1:PAGE_OFS_W],
                                   pending_addr_reg[PAGE_OFS_W-1:0]};
            default:  addr_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            paging_en_reg    <= 1'b0;
            dir_base_reg     <= '0;
            pending_addr_reg <= '0;
            tlb_valid_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PAGING_EN: paging_en_reg <= cfg_wdata[0];
                    CFG_DIR_BASE:  dir_base_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.pend_load) begin
                pending_addr_reg <= req.lin_addr;
            end
            if (cmd.flush) begin
                tlb_valid_reg <= '0;
            end else if (cmd.fill) begin
                tlb_valid_reg[fill_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            tlb_tag_reg[fill_slot]   <= pending_addr_reg[ADDR_W-1:PAGE_OFS_W];
            tlb_frame_reg[fill_slot] <= req.mem_data[ADDR_W-1:PAGE_OFS_W];
        end
        if (cmd.load_out) begin
            res_reg.out_kind <= cmd.kind;
            res_reg.out_addr <= addr_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

>>> hdl/paging_tlb_translate_unit.sv
// Top level of the paging TLB translate unit.
// Usage:
//   s_* carries one request per handshake: a translate (cmd 0), a memory word
//   returned for an earlier read request (cmd 1), or a TLB flush (cmd 2).
//   m_* carries results: a translated address, a memory read request, or a
//   directory / table not-present fault.
//   cfg_we writes paging enable (index 0) or directory base (index 1) at once.
// Timing:
//   Every request is decided in the cycle it is accepted; a result appears
//   in the output register on the next cycle. One request per cycle is
//   sustained while m_ready is high; lookup and compare are combinational.
//   A TLB miss issues a read request and waits for the memory word reply;
//   two round trips complete a walk, one if the directory entry is absent.
// Reset:
//   Clears paging enable, directory base, all TLB valid bits, the walk
//   phase and the output valid flag. No clearing pass is needed.
// Stall:
//   s_ready is high while the output register is empty or being taken, so
//   a held result blocks new requests only while m_ready is low.
`default_nettype none
module paging_tlb_translate_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ptlb_pkg::in_req_t              s_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ptlb_pkg::out_res_t             m_res,
    input  logic                           cfg_we,
    input  logic [ptlb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptlb_pkg::ADDR_W-1:0]    cfg_wdata
);
    import ptlb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ptlb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .req_cmd (s_req.cmd),
        .status  (status),
        .cmd     (cmd)
    );

    ptlb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (s_req),
        .cmd       (cmd),
        .status    (status),
        .res       (m_res)
    );

endmodule
`default_nettype wire

>>> hdl/ptlb_checker.sv
// Port-level checker for the paging TLB translate unit, with its bind.
`default_nettype none
module ptlb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ptlb_pkg::in_req_t   s_req,
    input logic                m_valid,
    input logic                m_ready,
    input ptlb_pkg::out_res_t  m_res
);
    import ptlb_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("result changed or dropped while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request stalled with empty output");

    a_flush_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req.cmd == CMD_FLUSH |=> !m_valid)
        else $error("flush produced a result");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_res.out_kind == KIND_DIR_FAULT || m_res.out_kind == KIND_TBL_FAULT)
        |-> m_res.out_addr == '0)
        else $error("fault result with nonzero address");

endmodule

bind paging_tlb_translate_unit ptlb_checker u_ptlb_checker (.*);
`default_nettype wire
